/* rtl/core/spcc_pkg.sv */
package spcc_pkg;

    localparam int unsigned IN_W  = 16;
    localparam int unsigned OUT_W = 16;
    localparam int unsigned Q_BITS = 16;
    localparam int unsigned LIM_SHIFT = 30;
    localparam logic [OUT_W-1:0] CORR_MAX = 16'h7FFF;

endpackage

/* rtl/core/spcc_if.sv */
interface spcc_in_if import spcc_pkg::*;;
    logic            valid;
    logic            ready;
    logic [IN_W-1:0] sample_x;
    logic [IN_W-1:0] sample_y;
    logic            last_pair;

    modport source (output valid, sample_x, sample_y, last_pair, input ready);
    modport sink   (input valid, sample_x, sample_y, last_pair, output ready);
endinterface

interface spcc_out_if import spcc_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] correlation;
    logic                    undefined;

    modport source (output valid, correlation, undefined, input ready);
    modport sink   (input valid, correlation, undefined, output ready);
endinterface

/* rtl/core/streaming_pearson_correlation_unit.sv */
// Each pair is accumulated through one shift-add multiplier, which the final pass shares.
// A last pair adds the final pass: six sum products, two wide products and sixteen trial
// steps of two products each; an undefined result skips the wide products and the trials.
// The input is ready only in the idle state; a finished result waits in the output register.
// Reset is asynchronous and active low; it clears the count, the sums and the output valid.
module streaming_pearson_correlation_unit import spcc_pkg::*; #(
    parameter int unsigned MAX_PAIRS   = 4096,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    spcc_in_if.sink    samples,
    spcc_out_if.source result
);

    localparam int unsigned SW  = (SAMPLE_BITS < IN_W) ? SAMPLE_BITS : IN_W;
    localparam int unsigned CW  = $clog2(MAX_PAIRS + 1);
    localparam int unsigned SXW = SW + CW;
    localparam int unsigned SQW = 2 * SW + CW;
    localparam int unsigned W   = 4 * (SW + CW) + 2 * Q_BITS;
    localparam int unsigned BW  = $clog2(Q_BITS);

    typedef enum logic [4:0] {
        S_IDLE, S_XX, S_YY, S_XY, S_NXX, S_SXX, S_NYY, S_SYY, S_NXY, S_SXY,
        S_CHK, S_PROD, S_LIM, S_TT, S_TP, S_FIN, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic           go_reg, go_next;
    logic [SW-1:0]  x_reg, x_next, y_reg, y_next;
    logic           last_reg, last_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [SXW-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic [SQW-1:0] sxx_sum_reg, sxx_sum_next, syy_sum_reg, syy_sum_next;
    logic [SQW-1:0] sxy_sum_reg, sxy_sum_next;
    logic [W-1:0]   t1_reg, t1_next, sxx_reg, sxx_next, syy_reg, syy_next;
    logic [W-1:0]   sxy_reg, sxy_next, prod_reg, prod_next, lim_reg, lim_next;
    logic [W-1:0]   tt_reg, tt_next;
    logic           neg_reg, neg_next;
    logic [Q_BITS-1:0] q_reg, q_next;
    logic [BW-1:0]  bit_reg, bit_next;
    logic [OUT_W-1:0] res_corr_reg, res_corr_next;
    logic           res_und_reg, res_und_next;
    logic           ov_reg, ov_next;
    logic [OUT_W-1:0] oc_reg, oc_next;
    logic           ou_reg, ou_next;

    logic           mul_start, mul_done, mul_state;
    logic [W-1:0]   mul_a, mul_b, mul_p;
    logic [Q_BITS-1:0] trial;

    assign trial = q_reg | (Q_BITS'(1) << bit_reg);

    spcc_mul #(.W(W)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        mul_state = 1'b1;
        case (state_reg)
            S_XX:    begin mul_a = W'(x_reg); mul_b = W'(x_reg); end
            S_YY:    begin mul_a = W'(y_reg); mul_b = W'(y_reg); end
            S_XY:    begin mul_a = W'(x_reg); mul_b = W'(y_reg); end
            S_NXX:   begin mul_a = W'(sxx_sum_reg); mul_b = W'(cnt_reg); end
            S_SXX:   begin mul_a = W'(sx_reg); mul_b = W'(sx_reg); end
            S_NYY:   begin mul_a = W'(syy_sum_reg); mul_b = W'(cnt_reg); end
            S_SYY:   begin mul_a = W'(sy_reg); mul_b = W'(sy_reg); end
            S_NXY:   begin mul_a = W'(sxy_sum_reg); mul_b = W'(cnt_reg); end
            S_SXY:   begin mul_a = W'(sx_reg); mul_b = W'(sy_reg); end
            S_PROD:  begin mul_a = sxx_reg; mul_b = syy_reg; end
            S_LIM:   begin mul_a = sxy_reg; mul_b = sxy_reg; end
            S_TT:    begin mul_a = W'(trial); mul_b = W'(trial); end
            S_TP:    begin mul_a = prod_reg; mul_b = tt_reg; end
            default: mul_state = 1'b0;
        endcase
        mul_start = mul_state && !go_reg;
    end

    assign samples.ready      = (state_reg == S_IDLE);
    assign result.valid       = ov_reg;
    assign result.correlation = oc_reg;
    assign result.undefined   = ou_reg;

    always_comb
    begin
        state_next    = state_reg;
        go_next       = go_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        last_next     = last_reg;
        cnt_next      = cnt_reg;
        sx_next       = sx_reg;
        sy_next       = sy_reg;
        sxx_sum_next  = sxx_sum_reg;
        syy_sum_next  = syy_sum_reg;
        sxy_sum_next  = sxy_sum_reg;
        t1_next       = t1_reg;
        sxx_next      = sxx_reg;
        syy_next      = syy_reg;
        sxy_next      = sxy_reg;
        prod_next     = prod_reg;
        lim_next      = lim_reg;
        tt_next       = tt_reg;
        neg_next      = neg_reg;
        q_next        = q_reg;
        bit_next      = bit_reg;
        res_corr_next = res_corr_reg;
        res_und_next  = res_und_reg;
        ov_next       = ov_reg && !result.ready;
        oc_next       = oc_reg;
        ou_next       = ou_reg;

        if (mul_start)
        begin
            go_next = 1'b1;
        end
        if (mul_done)
        begin
            go_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (samples.valid)
                begin
                    x_next    = samples.sample_x[SW-1:0];
                    y_next    = samples.sample_y[SW-1:0];
                    last_next = samples.last_pair;
                    if (cnt_reg < CW'(MAX_PAIRS))
                    begin
                        cnt_next   = cnt_reg + 1'b1;
                        sx_next    = sx_reg + SXW'(samples.sample_x[SW-1:0]);
                        sy_next    = sy_reg + SXW'(samples.sample_y[SW-1:0]);
                        state_next = S_XX;
                    end
                    else if (samples.last_pair)
                    begin
                        state_next = S_NXX;
                    end
                end
            end
            S_XX:
            begin
                if (mul_done)
                begin
                    sxx_sum_next = sxx_sum_reg + mul_p[SQW-1:0];
                    state_next   = S_YY;
                end
            end
            S_YY:
            begin
                if (mul_done)
                begin
                    syy_sum_next = syy_sum_reg + mul_p[SQW-1:0];
                    state_next   = S_XY;
                end
            end
            S_XY:
            begin
                if (mul_done)
                begin
                    sxy_sum_next = sxy_sum_reg + mul_p[SQW-1:0];
                    state_next   = last_reg ? S_NXX : S_IDLE;
                end
            end
            S_NXX:
            begin
                if (mul_done)
                begin
                    t1_next    = mul_p;
                    state_next = S_SXX;
                end
            end
            S_SXX:
            begin
                if (mul_done)
                begin
                    sxx_next   = t1_reg - mul_p;
                    state_next = S_NYY;
                end
            end
            S_NYY:
            begin
                if (mul_done)
                begin
                    t1_next    = mul_p;
                    state_next = S_SYY;
                end
            end
            S_SYY:
            begin
                if (mul_done)
                begin
                    syy_next   = t1_reg - mul_p;
                    state_next = S_NXY;
                end
            end
            S_NXY:
            begin
                if (mul_done)
                begin
                    t1_next    = mul_p;
                    state_next = S_SXY;
                end
            end
            S_SXY:
            begin
                if (mul_done)
                begin
                    neg_next   = (t1_reg < mul_p);
                    sxy_next   = (t1_reg < mul_p) ? (mul_p - t1_reg) : (t1_reg - mul_p);
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if ((sxx_reg == '0) || (syy_reg == '0))
                begin
                    res_corr_next = '0;
                    res_und_next  = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    state_next = S_PROD;
                end
            end
            S_PROD:
            begin
                if (mul_done)
                begin
                    prod_next  = mul_p;
                    state_next = S_LIM;
                end
            end
            S_LIM:
            begin
                if (mul_done)
                begin
                    lim_next   = mul_p << LIM_SHIFT;
                    q_next     = '0;
                    bit_next   = BW'(Q_BITS - 1);
                    state_next = S_TT;
                end
            end
            S_TT:
            begin
                if (mul_done)
                begin
                    tt_next    = mul_p;
                    state_next = S_TP;
                end
            end
            S_TP:
            begin
                if (mul_done)
                begin
                    if (mul_p <= lim_reg)
                    begin
                        q_next = trial;
                    end
                    if (bit_reg == '0)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        bit_next   = bit_reg - 1'b1;
                        state_next = S_TT;
                    end
                end
            end
            S_FIN:
            begin
                if (neg_reg)
                begin
                    res_corr_next = OUT_W'(0) - OUT_W'(q_reg);
                end
                else
                begin
                    res_corr_next = (q_reg > CORR_MAX) ? CORR_MAX : OUT_W'(q_reg);
                end
                res_und_next = 1'b0;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (!ov_reg || result.ready)
                begin
                    ov_next      = 1'b1;
                    oc_next      = res_corr_reg;
                    ou_next      = res_und_reg;
                    cnt_next     = '0;
                    sx_next      = '0;
                    sy_next      = '0;
                    sxx_sum_next = '0;
                    syy_sum_next = '0;
                    sxy_sum_next = '0;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            go_reg       <= 1'b0;
            x_reg        <= '0;
            y_reg        <= '0;
            last_reg     <= 1'b0;
            cnt_reg      <= '0;
            sx_reg       <= '0;
            sy_reg       <= '0;
            sxx_sum_reg  <= '0;
            syy_sum_reg  <= '0;
            sxy_sum_reg  <= '0;
            t1_reg       <= '0;
            sxx_reg      <= '0;
            syy_reg      <= '0;
            sxy_reg      <= '0;
            prod_reg     <= '0;
            lim_reg      <= '0;
            tt_reg       <= '0;
            neg_reg      <= 1'b0;
            q_reg        <= '0;
            bit_reg      <= '0;
            res_corr_reg <= '0;
            res_und_reg  <= 1'b0;
            ov_reg       <= 1'b0;
            oc_reg       <= '0;
            ou_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            go_reg       <= go_next;
            x_reg        <= x_next;
            y_reg        <= y_next;
            last_reg     <= last_next;
            cnt_reg      <= cnt_next;
            sx_reg       <= sx_next;
            sy_reg       <= sy_next;
            sxx_sum_reg  <= sxx_sum_next;
            syy_sum_reg  <= syy_sum_next;
            sxy_sum_reg  <= sxy_sum_next;
            t1_reg       <= t1_next;
            sxx_reg      <= sxx_next;
            syy_reg      <= syy_next;
            sxy_reg      <= sxy_next;
            prod_reg     <= prod_next;
            lim_reg      <= lim_next;
            tt_reg       <= tt_next;
            neg_reg      <= neg_next;
            q_reg        <= q_next;
            bit_reg      <= bit_next;
            res_corr_reg <= res_corr_next;
            res_und_reg  <= res_und_next;
            ov_reg       <= ov_next;
            oc_reg       <= oc_next;
            ou_reg       <= ou_next;
        end
    end

endmodule

/* rtl/core/spcc_mul.sv */
module spcc_mul #(
    parameter int unsigned W = 148
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic         done,
    output logic [W-1:0] p
);

    logic         busy_reg;
    logic [W-1:0] a_reg;
    logic [W-1:0] b_reg;
    logic [W-1:0] acc_reg;

    assign done = busy_reg && (b_reg == '0);
    assign p    = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            a_reg    <= '0;
            b_reg    <= '0;
            acc_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            a_reg    <= a;
            b_reg    <= b;
            acc_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (b_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                if (b_reg[0])
                begin
                    acc_reg <= acc_reg + a_reg;
                end
                a_reg <= a_reg << 1;
                b_reg <= b_reg >> 1;
            end
        end
    end

endmodule

/* rtl/core/spcc_checker.sv */
module spcc_checker import spcc_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             last_pair,
    input logic             out_valid,
    input logic             out_ready,
    input logic [OUT_W-1:0] correlation,
    input logic             undefined
);

    // An undefined result always carries a zero coefficient.
    a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && undefined |-> correlation == '0)
        else $error("undefined result with nonzero correlation");

    // A last pair always starts the final computation, so the input is busy next.
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_pair |=> !in_ready)
        else $error("input ready right after a last pair transaction");

    // A result cannot appear in the cycle right after an input transaction.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result produced without computation");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(correlation) && $stable(undefined))
        else $error("stalled result changed");

endmodule

bind streaming_pearson_correlation_unit spcc_checker u_spcc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (samples.valid),
    .in_ready    (samples.ready),
    .last_pair   (samples.last_pair),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .correlation (result.correlation),
    .undefined   (result.undefined)
);

/* tb/spcc_checker.sv */
module spcc_scoreboard import spcc_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    spcc_in_if         samples,
    spcc_out_if        result,
    output int         failures,
    output int         pending,
    output int         groups_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_PAIRS = 4096;

    typedef struct packed {
        logic signed [OUT_W-1:0] correlation;
        logic                    undefined;
    } corr_result_t;

    corr_result_t expected_results[$];
    logic [12:0]  pair_count;
    logic [255:0] sum_x, sum_y, sum_xx, sum_yy, sum_xy;

    function automatic corr_result_t compute_correlation();
        logic [255:0] n, sxx, syy, pa, pb, sxy, prod, lim;
        logic         neg;
        logic [15:0]  q, t;
        logic [31:0]  tt;
        corr_result_t r;
        n = 256'(pair_count);
        sxx = n * sum_xx - sum_x * sum_x;
        syy = n * sum_yy - sum_y * sum_y;
        pa = n * sum_xy;
        pb = sum_x * sum_y;
        neg = pa < pb;
        sxy = neg ? pb - pa : pa - pb;
        r.correlation = '0;
        r.undefined = 1'b0;
        if (sxx == 0 || syy == 0) begin
            r.undefined = 1'b1;
        end else begin
            prod = sxx * syy;
            lim = (sxy * sxy) << LIM_SHIFT;
            q = '0;
            for (int b = 15; b >= 0; b--) begin
                t = q | (16'd1 << b);
                tt = 32'(t) * 32'(t);
                if (256'(tt) * prod <= lim) q = t;
            end
            if (neg) r.correlation = 16'(17'h10000 - 17'(q));
            else r.correlation = (q > CORR_MAX) ? CORR_MAX : q;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pair_count = '0;
            sum_x = '0; sum_y = '0; sum_xx = '0; sum_yy = '0; sum_xy = '0;
            failures = 0;
            groups_seen = 0;
            pending = 0;
            expected_results.delete();
        end else begin
            if (result.valid && result.ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result transaction");
                    failures++;
                end else begin
                    corr_result_t e;
                    e = expected_results.pop_front();
                    if (result.correlation !== e.correlation) begin
                        $error("correlation expected %0d actual %0d", e.correlation,
                               result.correlation);
                        failures++;
                    end
                    if (result.undefined !== e.undefined) begin
                        $error("undefined expected %0b actual %0b", e.undefined,
                               result.undefined);
                        failures++;
                    end
                end
            end
            if (samples.valid && samples.ready) begin
                if (pair_count < MAX_PAIRS) begin
                    pair_count++;
                    sum_x += 256'(samples.sample_x);
                    sum_y += 256'(samples.sample_y);
                    sum_xx += 256'(32'(samples.sample_x) * 32'(samples.sample_x));
                    sum_yy += 256'(32'(samples.sample_y) * 32'(samples.sample_y));
                    sum_xy += 256'(32'(samples.sample_x) * 32'(samples.sample_y));
                end
                if (samples.last_pair) begin
                    expected_results.insert(expected_results.size(), compute_correlation());
                    groups_seen++;
                    pair_count = '0;
                    sum_x = '0; sum_y = '0; sum_xx = '0; sum_yy = '0; sum_xy = '0;
                end
            end
            pending = expected_results.size();
        end
    end
endmodule

/* tb/tb_streaming_pearson_correlation_unit.sv */
module tb_streaming_pearson_correlation_unit import spcc_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MODE_RANDOM   = 0;
    localparam int MODE_SAME     = 1;
    localparam int MODE_INVERTED = 2;
    localparam int MODE_NEAR     = 3;
    localparam int MODE_CONST_X  = 4;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   failures, pending, groups_seen;
    int   sent;
    bit   steady;

    spcc_in_if  samples();
    spcc_out_if result();

    streaming_pearson_correlation_unit dut (
        .clk(clk), .rst_n(rst_n), .samples(samples.sink), .result(result.source));

    spcc_scoreboard u_scoreboard (
        .clk(clk), .rst_n(rst_n), .samples(samples), .result(result),
        .failures(failures), .pending(pending), .groups_seen(groups_seen));

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        result.ready <= steady || ($urandom_range(99) >= 33);
    end

    task automatic send_pair(input logic [15:0] x, input logic [15:0] y, input logic last);
        while (!steady && $urandom_range(99) < 33)
        begin
            samples.valid <= 1'b0;
            @(posedge clk);
        end
        samples.valid <= 1'b1;
        samples.sample_x <= x;
        samples.sample_y <= y;
        samples.last_pair <= last;
        @(posedge clk);
        while (!samples.ready) @(posedge clk);
        sent++;
    endtask

    task automatic send_group(input int len, input int mode);
        logic [15:0] x, y, base;
        base = 16'($urandom);
        for (int i = 0; i < len; i++)
        begin
            x = 16'($urandom);
            y = 16'($urandom);
            case (mode)
                MODE_SAME:     y = x;
                MODE_INVERTED: y = ~x;
                MODE_NEAR:     y = x ^ 16'($urandom_range(255));
                MODE_CONST_X:  x = base;
                default: ;
            endcase
            send_pair(x, y, i == len - 1);
        end
    endtask

    initial
    begin
        int len;
        sent = 0;
        steady = 1'b0;
        samples.valid = 1'b0;
        samples.sample_x = '0;
        samples.sample_y = '0;
        samples.last_pair = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_pair(16'h1234, 16'h5678, 1'b1);
        send_pair(16'h0000, 16'h0000, 1'b0);
        send_pair(16'hFFFF, 16'hFFFF, 1'b1);
        send_pair(16'h0000, 16'hFFFF, 1'b0);
        send_pair(16'hFFFF, 16'h0000, 1'b1);
        send_pair(16'h0000, 16'h0000, 1'b0);
        send_pair(16'hFFFF, 16'h0000, 1'b0);
        send_pair(16'h0000, 16'hFFFF, 1'b1);
        send_pair(16'h0005, 16'h1111, 1'b0);
        send_pair(16'h0005, 16'h2222, 1'b0);
        send_pair(16'h0005, 16'h3333, 1'b1);
        send_group(4, MODE_SAME);
        send_group(4, MODE_INVERTED);
        send_group(5, MODE_RANDOM);
        while (sent < 1700)
        begin
            steady = (sent > 800 && sent < 1000);
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
            send_group(len, $urandom_range(5));
        end
        steady = 1'b0;
        samples.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (3000) @(posedge clk);
        $display("Sent %0d pair transactions in %0d groups, including constant,", sent,
                 groups_seen);
        $display("identical, inverted and long groups, under random stalls.");
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #400ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule

/* files.f */
rtl/core/spcc_pkg.sv
rtl/core/spcc_if.sv
rtl/core/spcc_mul.sv
rtl/core/streaming_pearson_correlation_unit.sv
rtl/core/spcc_checker.sv
tb/spcc_checker.sv
tb/tb_streaming_pearson_correlation_unit.sv
